>>> rtl/sliding_window_percentile_unit_macros.svh
// Assertion macros shared by the sliding window percentile RTL.
`ifndef SLIDING_WINDOW_PERCENTILE_UNIT_MACROS_SVH
`define SLIDING_WINDOW_PERCENTILE_UNIT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define SWP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swp: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define SWP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swp: next-cycle check failed");

`endif

>>> rtl/swp_pkg.sv
// Types and constants of the sliding window percentile unit.
package swp_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned FILL_W   = 7;

    // floor(c*95/100) == (c * K95) >> K95_SH for every fill count up to 1024
    localparam int unsigned K95_W  = 24;
    localparam int unsigned K95_SH = 24;
    localparam logic [K95_W-1:0] K95 = 24'd15938435;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVICT,
        S_INSERT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_EVICT,
        OP_INSERT
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [SAMPLE_W-1:0] key;
    } t_cell_ctl;

    typedef struct packed {
        logic [SAMPLE_W-1:0] val;
        logic                vld;
        logic                hit;
    } t_link;

endpackage

>>> rtl/swp_if.sv
// Valid/ready item channels of the sliding window percentile unit.
interface swp_in_if import swp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swp_out_if import swp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] median;
    logic [SAMPLE_W-1:0] pct95;
    logic [SAMPLE_W-1:0] maximum;
    logic [FILL_W-1:0]   fill_count;

    modport source (output valid, output median, output pct95, output maximum,
                    output fill_count, input ready);
    modport sink   (input valid, input median, input pct95, input maximum,
                    input fill_count, output ready);
endinterface

>>> rtl/swp_cell.sv
// One slot of the sorted sample chain: evicts by shifting down, inserts by shifting up.
module swp_cell import swp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_link     i_left,
    input  t_link     i_right,
    output t_link     o_link
);

    logic [SAMPLE_W-1:0] r_val, n_val;
    logic                r_vld, n_vld;
    logic                w_hit;

    // invalid slots sort as +infinity
    always_comb begin
        if (i_ctl.op == OP_EVICT) begin
            w_hit = !r_vld || (r_val >= i_ctl.key);
        end else begin
            w_hit = !r_vld || (r_val > i_ctl.key);
        end
    end

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        case (i_ctl.op)
            OP_EVICT: begin
                if (w_hit) begin
                    n_val = i_right.val;
                    n_vld = i_right.vld;
                end
            end
            OP_INSERT: begin
                if (w_hit) begin
                    if (i_left.hit) begin
                        n_val = i_left.val;
                        n_vld = i_left.vld;
                    end else begin
                        n_val = i_ctl.key;
                        n_vld = 1'b1;
                    end
                end
            end
            default: begin
                n_val = r_val;
                n_vld = r_vld;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link = '{val: r_val, vld: r_vld, hit: w_hit};

endmodule

>>> rtl/swp_ring.sv
// Ring of recent samples; read-before-write returns the slot's oldest sample.
module swp_ring import swp_pkg::*; #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_addr,
    input  logic [SAMPLE_W-1:0] i_wdata,
    output logic [SAMPLE_W-1:0] o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_addr];
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sliding_window_percentile_unit.sv
// Top level of the sliding window percentile unit.
// Keeps the latest WINDOW_DEPTH latency samples in a ring and, in parallel, as an
// ascending chain of cells. For each accepted item the unit reports the chain entry
// at index count/2 (median), at count*95/100 (95th percentile), the largest entry and
// the fill count, saturating at WINDOW_DEPTH. Each item goes from accept to the output
// register in steps: the accept cycle reads the oldest sample out of the ring memory,
// an evict pass over the cell chain (full window only) drops it, an insert pass places
// the new sample, and a last step, which waits while the previous result is still held
// for the sink, selects the three ranks into the output register. The next item can be
// accepted the cycle after that load, while the result may still wait for the sink.
`include "sliding_window_percentile_unit_macros.svh"

module sliding_window_percentile_unit import swp_pkg::*; #(
    parameter int unsigned WINDOW_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swp_in_if.sink    i_smp,
    swp_out_if.source o_res
);

    localparam int unsigned IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned PW = CW + K95_W;

    t_state              r_state, n_state;
    logic [IW-1:0]       r_slot, n_slot;
    logic [CW-1:0]       r_count, n_count;
    logic [SAMPLE_W-1:0] r_key;
    logic [IW-1:0]       r_i50, r_i95, r_imax;
    logic [PW-1:0]       w_prod;

    logic                r_out_vld;
    logic [SAMPLE_W-1:0] r_med, r_p95, r_max;
    logic [FILL_W-1:0]   r_fill;
    logic [SAMPLE_W-1:0] n_med, n_p95, n_max;

    logic                w_accept;
    logic                w_full;
    logic                w_load;
    t_cell_ctl           w_ctl;
    logic [SAMPLE_W-1:0] w_oldest;

    t_link               w_link [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] w_vld;

    localparam t_link EDGE = '{val: '0, vld: 1'b0, hit: 1'b0};

    assign w_accept = i_smp.valid && i_smp.ready;
    assign w_full   = (r_count == CW'(WINDOW_DEPTH));
    assign n_slot   = (r_slot == IW'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    assign n_count  = w_full ? r_count : r_count + 1'b1;
    assign w_prod   = PW'(n_count) * PW'(K95);

    swp_ring #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (IW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_addr  (r_slot),
        .i_wdata (i_smp.sample),
        .o_rdata (w_oldest)
    );

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        t_link w_left, w_right;
        if (g == 0) begin : g_first
            assign w_left = EDGE;
        end else begin : g_inner_l
            assign w_left = w_link[g-1];
        end
        if (g == WINDOW_DEPTH - 1) begin : g_last
            assign w_right = EDGE;
        end else begin : g_inner_r
            assign w_right = w_link[g+1];
        end
        swp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );
        assign w_vld[g] = w_link[g].vld;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_full ? S_EVICT : S_INSERT;
                end
            end
            S_EVICT: begin
                n_state = S_INSERT;
            end
            S_INSERT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        i_smp.ready = 1'b0;
        w_load      = 1'b0;
        w_ctl       = '{op: OP_HOLD, key: r_key};
        case (r_state)
            S_IDLE: begin
                i_smp.ready = 1'b1;
            end
            S_EVICT: begin
                w_ctl = '{op: OP_EVICT, key: w_oldest};
            end
            S_INSERT: begin
                w_ctl = '{op: OP_INSERT, key: r_key};
            end
            S_OUT: begin
                w_load = !r_out_vld || o_res.ready;
            end
            default: begin
                i_smp.ready = 1'b0;
            end
        endcase
    end

    // rank selection over the chain
    always_comb begin
        n_med = '0;
        n_p95 = '0;
        n_max = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (IW'(i) == r_i50) begin
                n_med = n_med | w_link[i].val;
            end
            if (IW'(i) == r_i95) begin
                n_p95 = n_p95 | w_link[i].val;
            end
            if (IW'(i) == r_imax) begin
                n_max = n_max | w_link[i].val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slot    <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_slot <= n_slot;
            end
            if (r_state == S_INSERT) begin
                r_count <= n_count;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_smp.sample;
        end
        if (r_state == S_INSERT) begin
            r_i50  <= IW'(n_count >> 1);
            r_i95  <= IW'(w_prod >> K95_SH);
            r_imax <= IW'(n_count - 1'b1);
        end
        if (w_load) begin
            r_med  <= n_med;
            r_p95  <= n_p95;
            r_max  <= n_max;
            r_fill <= FILL_W'(r_count);
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.median     = r_med;
    assign o_res.pct95      = r_p95;
    assign o_res.maximum    = r_max;
    assign o_res.fill_count = r_fill;

    `SWP_ASSERT_NEXT(a_accept_pass, i_clk, i_rst_n, w_accept, r_state == S_EVICT || r_state == S_INSERT)
    `SWP_ASSERT_IMPL(a_evict_full, i_clk, i_rst_n, r_state == S_EVICT, w_full)
    `SWP_ASSERT_IMPL(a_chain_fill, i_clk, i_rst_n, r_state == S_OUT, $countones(w_vld) == int'(r_count))
    `SWP_ASSERT_NEXT(a_fill_out, i_clk, i_rst_n, w_load, o_res.valid && o_res.fill_count == FILL_W'(r_count))

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the sliding window percentile unit.
module tb_top;
    import swp_pkg::*;

    localparam int unsigned DEPTH       = 64;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_WAIT  = 16;
    localparam int unsigned ITEM_COUNT  = 450;

    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample           median;
        t_sample           pct95;
        t_sample           maximum;
        logic [FILL_W-1:0] fill_count;
    } t_rank_set;

    logic i_clk;
    logic i_rst_n;

    swp_in_if  smp_if ();
    swp_out_if res_if ();

    sliding_window_percentile_unit #(
        .WINDOW_DEPTH(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_smp  (smp_if),
        .o_res  (res_if)
    );

    t_sample     sample_q[$];
    t_rank_set   rank_q[$];
    t_sample     latency_ring[DEPTH];
    int unsigned ring_slot;
    int unsigned held;
    int unsigned send_gap;
    int unsigned send_calm;
    int unsigned recv_stall;
    int unsigned recv_calm;
    int unsigned cycle_count;
    bit          failed;

    // Quiet stretches come in runs so that back-to-back traffic is exercised too.
    function automatic int unsigned draw_wait(inout int unsigned calm_left);
        if (calm_left != 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic predict_ranks(input t_sample s);
        t_sample     ordered[DEPTH];
        t_sample     v;
        int unsigned j;
        t_rank_set   r;
        latency_ring[ring_slot] = s;
        ring_slot = (ring_slot + 1) % DEPTH;
        if (held < DEPTH)
            held++;
        for (int unsigned i = 0; i < held; i++) begin
            v = latency_ring[i];
            j = i;
            while (j > 0 && ordered[j-1] > v) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end
        r.median     = ordered[held / 2];
        r.pct95      = ordered[(held * 95) / 100];
        r.maximum    = ordered[held - 1];
        r.fill_count = held[FILL_W-1:0];
        rank_q.push_back(r);
    endtask

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (smp_if.valid && smp_if.ready)
                predict_ranks(smp_if.sample);
            if (!smp_if.valid || smp_if.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    smp_if.valid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    smp_if.valid  <= 1'b1;
                    smp_if.sample <= sample_q.pop_front();
                    send_gap = draw_wait(send_calm);
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_rank_set want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (rank_q.size() == 0) begin
                    $error("result item with nothing expected");
                    failed = 1'b1;
                end else begin
                    want = rank_q.pop_front();
                    if (res_if.median !== want.median) begin
                        $error("median: expected %0h, got %0h", want.median, res_if.median);
                        failed = 1'b1;
                    end
                    if (res_if.pct95 !== want.pct95) begin
                        $error("pct95: expected %0h, got %0h", want.pct95, res_if.pct95);
                        failed = 1'b1;
                    end
                    if (res_if.maximum !== want.maximum) begin
                        $error("maximum: expected %0h, got %0h", want.maximum,
                               res_if.maximum);
                        failed = 1'b1;
                    end
                    if (res_if.fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, got %0d", want.fill_count,
                               res_if.fill_count);
                        failed = 1'b1;
                    end
                end
                recv_stall = draw_wait(recv_calm);
            end
            if (recv_stall != 0) begin
                recv_stall--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned run_len;
        int unsigned mode;
        t_sample     base;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        res_if.ready  = 1'b0;
        ring_slot     = 0;
        held          = 0;
        send_gap      = 0;
        send_calm     = 0;
        recv_stall    = 0;
        recv_calm     = 0;
        cycle_count   = 0;
        failed        = 1'b0;

        // directed: extremes, single bits, duplicates, descending run
        sample_q.push_back(32'h0000_0000);
        sample_q.push_back(32'hFFFF_FFFF);
        sample_q.push_back(32'h8000_0000);
        sample_q.push_back(32'h0000_0001);
        sample_q.push_back(32'h7FFF_FFFF);
        sample_q.push_back(32'hFFFF_FFFF);
        sample_q.push_back(32'h0000_0000);
        sample_q.push_back(32'h5555_5555);
        sample_q.push_back(32'hAAAA_AAAA);
        for (int i = 0; i < 3; i++)
            sample_q.push_back(32'd5);
        for (int i = 0; i < 12; i++)
            sample_q.push_back(32'hFFFF_FFF0 - i * 32'h1111_1111);

        // random runs; many exceed the window so eviction is covered
        while (sample_q.size() < ITEM_COUNT) begin
            run_len = $urandom_range(10, 90);
            mode    = $urandom_range(0, 4);
            base    = $urandom;
            for (int unsigned k = 0; k < run_len && sample_q.size() < ITEM_COUNT; k++) begin
                case (mode)
                    0: sample_q.push_back($urandom);
                    1: sample_q.push_back($urandom_range(0, 15));
                    2: sample_q.push_back(base + k * $urandom_range(0, 1000));
                    3: sample_q.push_back(base - k * $urandom_range(0, 1000));
                    default: begin
                        case ($urandom_range(0, 3))
                            0: sample_q.push_back(32'h0000_0000);
                            1: sample_q.push_back(32'hFFFF_FFFF);
                            2: sample_q.push_back(32'hFFFF_FFFF - $urandom_range(0, 3));
                            default: sample_q.push_back(32'd1 << $urandom_range(0, 31));
                        endcase
                    end
                endcase
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sample_q.size() != 0 || smp_if.valid || rank_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (rank_q.size() != 0) begin
            $error("%0d result items never arrived", rank_q.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
